>>> rtl/fpa_pkg.sv
// package with opcodes and the item type shared by the alu modules
`default_nettype none
package fpa_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 4;

  // opcodes of a request
  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_DIV   = 4'd3,
    OP_MIN   = 4'd4,
    OP_MAX   = 4'd5,
    OP_INC   = 4'd6,
    OP_DEC   = 4'd7,
    OP_TOINT = 4'd8
  } op_t;

  // classified request as it travels from front to back
  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic                     lt;
    logic                     eq;
    logic                     gt;
    logic                     dz;
  } fpa_item_t;

endpackage
`default_nettype wire

>>> rtl/fixed_point_alu_q24_8_top.sv
// top level of the signed q24.8 fixed-point alu
// path: front register, queue, stage 0, divider stages, rounding register, result register
// throughput: one operation per cycle while busy is low, set by the one-bit-per-stage divider pipeline
// busy only rises if the front queue fills; results cannot be held off
// rst is synchronous: clears the queue and all valid bits, no result is pending after it
`default_nettype none
module fixed_point_alu_q24_8_top #(
  parameter int FRAC_BITS = 8,
  parameter int WORD_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [fpa_pkg::OP_W-1:0]          req_type,
  input  wire logic signed [fpa_pkg::DATA_W-1:0] operand_a,
  input  wire logic signed [fpa_pkg::DATA_W-1:0] operand_b,
  output logic                                   done,
  output logic signed [fpa_pkg::DATA_W-1:0]      result_raw,
  output logic                                   a_less,
  output logic                                   a_equal,
  output logic                                   a_greater,
  output logic                                   overflow,
  output logic                                   div_zero
);
  import fpa_pkg::*;

  logic      push;
  logic      room;
  logic      pop;
  fpa_item_t f_item;
  fpa_item_t q_item;

  // request front end
  fpa_front u_front (
    .clk, .rst, .start, .req_type, .operand_a, .operand_b,
    .room, .busy, .push, .item(f_item)
  );

  // decoupling queue
  fpa_queue #(.DEPTH(4)) u_queue (
    .clk, .rst, .push, .push_item(f_item), .room, .pop, .pop_item(q_item)
  );

  // execution back end
  fpa_back #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_back (
    .clk, .rst, .in_valid(pop), .in_item(q_item),
    .done, .result_raw, .a_less, .a_equal, .a_greater, .overflow, .div_zero
  );

endmodule
`default_nettype wire

>>> rtl/fpa_front.sv
// front end: takes a request beat, compares the operands and flags divide by zero
`default_nettype none
module fpa_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [fpa_pkg::OP_W-1:0]      req_type,
  input  wire logic signed [fpa_pkg::DATA_W-1:0] operand_a,
  input  wire logic signed [fpa_pkg::DATA_W-1:0] operand_b,
  input  wire logic                          room,
  output logic                               busy,
  output logic                               push,
  output fpa_pkg::fpa_item_t                 item
);
  import fpa_pkg::*;

  logic      accept;
  fpa_item_t item_next;

  // take a beat only while the queue has space for it
  assign busy   = !room;
  assign accept = start && !busy;

  // classify the request
  always_comb begin
    item_next.op = req_type;
    item_next.a  = operand_a;
    item_next.b  = operand_b;
    item_next.lt = operand_a < operand_b;
    item_next.eq = operand_a == operand_b;
    item_next.gt = operand_a > operand_b;
    item_next.dz = (req_type == OP_DIV) && (operand_b == '0);
  end

  // front register
  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      push <= accept;
    end
    item <= item_next;
  end

endmodule
`default_nettype wire

>>> rtl/fpa_queue.sv
// short queue between the front end and the execution back end
`default_nettype none
module fpa_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire fpa_pkg::fpa_item_t push_item,
  output logic                    room,
  output logic                    pop,
  output fpa_pkg::fpa_item_t      pop_item
);
  import fpa_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fpa_item_t     mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;

  // the back end drains a beat every cycle it can
  assign pop      = count != '0;
  assign pop_item = mem[rptr];
  // keep one place for the beat in the front register
  assign room     = (count + CW'(push)) <= CW'(DEPTH - 2);

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule
`default_nettype wire

>>> rtl/fpa_back.sv
// back end: multiplier, pipelined restoring divider, rounding and saturation
`default_nettype none
module fpa_back #(
  parameter int FRAC_BITS = 8,
  parameter int WORD_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire fpa_pkg::fpa_item_t in_item,
  output logic                    done,
  output logic signed [fpa_pkg::DATA_W-1:0] result_raw,
  output logic                    a_less,
  output logic                    a_equal,
  output logic                    a_greater,
  output logic                    overflow,
  output logic                    div_zero
);
  import fpa_pkg::*;

  localparam int NUMW = DATA_W + FRAC_BITS;
  localparam int RES  = (WORD_BITS > DATA_W) ? DATA_W : WORD_BITS;
  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (RES - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
  localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic              lt;
    logic              eq;
    logic              gt;
    logic              dz;
    logic              qneg;
    logic signed [63:0] r;
    logic [DATA_W-1:0] den;
    logic [DATA_W-1:0] rem;
    logic [NUMW-1:0]   nq;
  } dstage_t;

  // one quotient bit: shift in a numerator bit, subtract when it fits
  function automatic dstage_t div_step(input dstage_t s);
    dstage_t          n;
    logic [DATA_W:0]   remsh;
    logic [DATA_W+1:0] diff;
    logic              ge;
    n     = s;
    remsh = {s.rem, s.nq[NUMW-1]};
    diff  = {1'b0, remsh} - {2'b00, s.den};
    ge    = !diff[DATA_W+1];
    n.rem = ge ? diff[DATA_W-1:0] : remsh[DATA_W-1:0];
    n.nq  = {s.nq[NUMW-2:0], ge};
    return n;
  endfunction

  // stage 0: operands and product
  logic               s0_v;
  fpa_item_t          s0_it;
  logic signed [63:0] s0_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else begin
      s0_v <= in_valid;
    end
    s0_it   <= in_item;
    s0_prod <= in_item.a * in_item.b;
  end

  // plain ops, multiply rounding and divider setup
  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;
  logic [63:0]       prod_mag;
  logic [63:0]       mul_m;
  logic [63:0]       int_m;
  logic signed [63:0] r_pre;
  dstage_t           d0_next;

  always_comb begin
    mag_a    = s0_it.a[DATA_W-1] ? (~s0_it.a + 1'b1) : s0_it.a;
    mag_b    = s0_it.b[DATA_W-1] ? (~s0_it.b + 1'b1) : s0_it.b;
    prod_mag = s0_prod[63] ? (~s0_prod + 1'b1) : s0_prod;
    mul_m    = (prod_mag + HALF) >> FRAC_BITS;
    int_m    = (64'(mag_a) + HALF) >> FRAC_BITS;
    case (s0_it.op)
      OP_ADD:   r_pre = 64'(s0_it.a) + 64'(s0_it.b);
      OP_SUB:   r_pre = 64'(s0_it.a) - 64'(s0_it.b);
      OP_MUL:   r_pre = s0_prod[63] ? -$signed(mul_m) : $signed(mul_m);
      OP_MIN:   r_pre = s0_it.lt ? 64'(s0_it.a) : 64'(s0_it.b);
      OP_MAX:   r_pre = s0_it.gt ? 64'(s0_it.a) : 64'(s0_it.b);
      OP_INC:   r_pre = 64'(s0_it.a) + 64'sd1;
      OP_DEC:   r_pre = 64'(s0_it.a) - 64'sd1;
      OP_TOINT: r_pre = s0_it.a[DATA_W-1] ? -$signed(int_m) : $signed(int_m);
      default:  r_pre = '0;
    endcase
    d0_next.op   = s0_it.op;
    d0_next.lt   = s0_it.lt;
    d0_next.eq   = s0_it.eq;
    d0_next.gt   = s0_it.gt;
    d0_next.dz   = s0_it.dz;
    d0_next.qneg = s0_it.a[DATA_W-1] ^ s0_it.b[DATA_W-1];
    d0_next.r    = r_pre;
    d0_next.den  = mag_b;
    d0_next.rem  = '0;
    d0_next.nq   = {mag_a, {FRAC_BITS{1'b0}}};
  end

  // divider pipeline, one quotient bit per stage
  dstage_t dv  [NUMW+1];
  logic    dvv [NUMW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dvv[0] <= 1'b0;
    end else begin
      dvv[0] <= s0_v;
    end
    dv[0] <= d0_next;
  end

  for (genvar k = 0; k < NUMW; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[k+1] <= 1'b0;
      end else begin
        dvv[k+1] <= dvv[k];
      end
      dv[k+1] <= div_step(dv[k]);
    end
  end

  // quotient rounding and sign
  logic               f1_v;
  dstage_t            f1;
  dstage_t            f1_next;
  logic [63:0]        q_rnd;
  logic signed [63:0] r_div;

  always_comb begin
    q_rnd = 64'(dv[NUMW].nq) +
            64'({dv[NUMW].rem, 1'b0} >= {1'b0, dv[NUMW].den});
    r_div = dv[NUMW].qneg ? -$signed(q_rnd) : $signed(q_rnd);
    f1_next = dv[NUMW];
    if (dv[NUMW].op == OP_DIV) begin
      f1_next.r = dv[NUMW].dz ? 64'sd0 : r_div;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
    end else begin
      f1_v <= dvv[NUMW];
    end
    f1 <= f1_next;
  end

  // saturation and result register
  logic sat_op;
  logic hi_ovf;
  logic lo_ovf;

  always_comb begin
    sat_op = f1.op <= OP_DEC;
    hi_ovf = sat_op && (f1.r > SAT_HI);
    lo_ovf = sat_op && (f1.r < SAT_LO);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= f1_v;
    end
    result_raw <= hi_ovf ? SAT_HI[DATA_W-1:0] :
                  lo_ovf ? SAT_LO[DATA_W-1:0] : f1.r[DATA_W-1:0];
    overflow   <= hi_ovf || lo_ovf;
    div_zero   <= f1.dz;
    a_less     <= f1.lt;
    a_equal    <= f1.eq;
    a_greater  <= f1.gt;
  end

endmodule
`default_nettype wire

>>> rtl/fpa_checker.sv
// port-level checks of the alu results, bound to the top level
`default_nettype none
module fpa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        done,
  input wire logic [31:0] result_raw,
  input wire logic        a_less,
  input wire logic        a_equal,
  input wire logic        a_greater,
  input wire logic        overflow,
  input wire logic        div_zero
);

  // exactly one compare flag per result beat
  a_cmp_onehot: assert property (@(posedge clk) disable iff (rst)
    done |-> $onehot({a_less, a_equal, a_greater}))
    else $error("compare flags not one-hot");

  // divide by zero gives zero and no overflow
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    done && div_zero |-> result_raw == 32'd0 && !overflow)
    else $error("divide by zero result wrong");

  // equal operands raise no ordering flag
  a_eq_flags: assert property (@(posedge clk) disable iff (rst)
    done && a_equal |-> !a_less && !a_greater)
    else $error("equal with ordering flag");

  // no result beat right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst && $past(rst) |-> !done)
    else $error("result beat after reset");

endmodule

bind fixed_point_alu_q24_8_top fpa_checker u_fpa_checker (.*);
`default_nettype wire
